/* rtl/user_failure_throttle_table_assert.svh */
// assertion macros for the failure throttle table
// no dependencies
`ifndef USER_FAILURE_THROTTLE_TABLE_ASSERT_SVH
`define USER_FAILURE_THROTTLE_TABLE_ASSERT_SVH

// implication checked on every clock, quiet in reset
`define UFTT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("uftt check failed");

// next-cycle implication
`define UFTT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("uftt check failed");

`endif

/* rtl/uftt_pkg.sv */
// shared types and constants for the failure throttle table
// no dependencies
package uftt_pkg;
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_CHECK  = 2'd1;
	localparam logic [1:0] OP_FAIL   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic REG_BASE    = 1'b0;
	localparam logic REG_LOCKOUT = 1'b1;

	localparam logic [15:0] BASE_RESET    = 16'd30000;
	localparam logic [31:0] LOCKOUT_RESET = 32'd86400000;
	localparam logic [31:0] LOCKOUT_COUNT = 32'd140;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] user_id;
		logic [63:0] timestamp_ms;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] failure_count;
		logic [63:0] last_time;
		logic        throttled;
		logic [31:0] remaining_ms;
	} rsp_t;

	// one record with its valid flag
	typedef struct packed {
		logic        valid;
		logic [63:0] id;
		logic [31:0] count;
		logic [63:0] tm;
	} rec_t;

	// scan token accumulated at the head cell as the records rotate past it
	typedef struct packed {
		logic        hit;
		logic [31:0] count;
		logic [63:0] tm;
		logic        old_any;
		logic [63:0] old_tm;
	} scan_t;
endpackage

/* rtl/uftt_if.sv */
// valid/ready channel interfaces for requests, results and config
// depends on uftt_pkg
interface uftt_req_if import uftt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uftt_rsp_if import uftt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uftt_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] index;
	logic [63:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/user_failure_throttle_table.sv */
// failure throttle table, records rotate through a ring of ENTRIES cells
// a request is scanned through a full rotation past the head, then the result is computed;
// when the record is written back, a second full rotation places it before the result beat
// one request at a time, limited by the single compare port at the head of the ring; a
// new request is taken only once the last one is through, and a held result beat stalls the input
// reset clears config to defaults and marks all slots empty; no clearing pass
module user_failure_throttle_table import uftt_pkg::*; #(
	parameter int ENTRIES = 32
) (
	input logic        clk,
	input logic        arst_n,
	uftt_req_if.sink   req,
	uftt_rsp_if.source rsp,
	uftt_cfg_if.sink   cfg
);
`include "user_failure_throttle_table_assert.svh"

	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_ROT  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] fill_q;
	logic [15:0]   base_q;
	logic [31:0]   lock_q;
	req_t          req_q;
	scan_t         acc_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          wr_q;
	logic          wmode_q;
	logic [31:0]   wcnt_q;
	logic [63:0]   wtm_q;
	logic [31:0]   tmo_q;
	logic [CW-1:0] old_pos_q;

	rec_t  ring  [ENTRIES];
	rec_t  rin   [ENTRIES];
	scan_t sc_in;
	scan_t sc_out;
	logic  shift;
	logic  cmp;
	logic  place;
	logic  old_take;
	rec_t  head_new;

	assign cfg.ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			lock_q <= LOCKOUT_RESET;
		end else if (cfg.valid && cfg.index[63:1] == '0) begin
			unique case (cfg.index[0])
				REG_BASE:    base_q <= cfg.wdata[15:0];
				REG_LOCKOUT: lock_q <= cfg.wdata[31:0];
				default: ;
			endcase
		end
	end

	// ring of cells; cell 0 is the head, records move toward lower indexes
	assign shift = (state_q == ST_SCAN) || (state_q == ST_ROT);
	assign cmp   = (state_q == ST_SCAN);
	assign sc_in = acc_q;

	// head record becomes the oldest seen so far (last one on ties)
	assign old_take = cmp && ring[0].valid && !acc_q.hit && ring[0].id != req_q.user_id
		&& (!acc_q.old_any || ring[0].tm <= acc_q.old_tm);

	// write placement at the head during rotation
	always_comb begin
		head_new = ring[0];
		place    = 1'b0;
		if (state_q == ST_ROT && wr_q) begin
			if (ring[0].valid && ring[0].id == req_q.user_id) begin
				place = 1'b1;
			end else if (!wmode_q && !ring[0].valid) begin
				place = 1'b1;
			end else if (wmode_q && (CW'(ENTRIES) - cnt_q) == old_pos_q) begin
				place = 1'b1;
			end
		end
		if (place) begin
			head_new.valid = 1'b1;
			head_new.id    = req_q.user_id;
			head_new.count = wcnt_q;
			head_new.tm    = wtm_q;
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		scan_t sc_dummy;
		if (g == ENTRIES - 1) begin : g_tail
			assign rin[g] = head_new;
		end else begin : g_mid
			assign rin[g] = ring[g + 1];
		end
		if (g == 0) begin : g_head
			uftt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clr(1'b0), .shift(shift),
				.rec_in(rin[g]), .rec_out(ring[g]), .key(req_q.user_id),
				.cmp(cmp), .scan_in(sc_in), .scan_out(sc_out)
			);
		end else begin : g_rest
			uftt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clr(1'b0), .shift(shift),
				.rec_in(rin[g]), .rec_out(ring[g]), .key(req_q.user_id),
				.cmp(1'b0), .scan_in(acc_q), .scan_out(sc_dummy)
			);
		end
	end

	// timeout from count
	function automatic logic [31:0] backoff(input logic [31:0] c, input logic [15:0] b,
		input logic [31:0] l);
		logic [31:0] k;
		logic [3:0]  sh;
		logic [47:0] wide;
		k    = c - 32'd30;
		sh   = 4'd0;
		wide = '0;
		if (c == 32'd0) begin
			backoff = '0;
		end else if (c <= 32'd10) begin
			backoff = (c == 32'd5 || c == 32'd10) ? {16'd0, b} : 32'd0;
		end else if (c < 32'd30) begin
			backoff = {16'd0, b};
		end else if (c < LOCKOUT_COUNT) begin
			// k below 110: divide by ten via reciprocal
			sh      = 4'((k * 32'd205) >> 11);
			wide    = {32'd0, b} << sh;
			backoff = wide[31:0];
		end else begin
			backoff = l;
		end
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
			wr_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CW'(ENTRIES - 1)) begin
						state_q <= ST_CALC;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_CALC: begin
					state_q <= ST_OUT;
					wr_q    <= 1'b0;
					unique case (req_q.operation) inside
						OP_LOOKUP: ;
						OP_CHECK: begin
							if (tmo_q != '0 && req_q.timestamp_ms <= acc_q.tm) begin
								wr_q <= 1'b1;
							end
						end
						OP_FAIL, OP_CLEAR: wr_q <= 1'b1;
						default: ;
					endcase
					rsp_valid_q <= 1'b0;
				end
				ST_OUT: begin
					if (wr_q) begin
						state_q <= ST_ROT;
						cnt_q   <= CW'(ENTRIES);
						if (!acc_q.hit && fill_q != CW'(ENTRIES)) begin
							fill_q <= fill_q + 1'b1;
						end
					end else begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				ST_ROT: begin
					if (place) begin
						wr_q <= 1'b0;
					end
					if (cnt_q == CW'(1)) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
					end
					cnt_q <= cnt_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.data;
			acc_q <= '0;
		end else if (cmp) begin
			acc_q <= sc_out;
		end
		// slot of the replacement victim, by scan position
		if (old_take) begin
			old_pos_q <= cnt_q;
		end
		if (state_q == ST_CALC || state_q == ST_SCAN) begin
			tmo_q <= backoff(sc_out.hit ? sc_out.count : 32'd0, base_q, lock_q);
		end
		if (state_q == ST_CALC) begin
			wmode_q           <= !acc_q.hit && fill_q == CW'(ENTRIES);
			rsp_q.found       <= acc_q.hit;
			rsp_q.throttled   <= 1'b0;
			rsp_q.remaining_ms <= '0;
			rsp_q.failure_count <= acc_q.count;
			rsp_q.last_time   <= acc_q.tm;
			wcnt_q            <= acc_q.count;
			wtm_q             <= acc_q.tm;
			unique case (req_q.operation)
				OP_LOOKUP: ;
				OP_CHECK: begin
					if (tmo_q != '0) begin
						if (req_q.timestamp_ms > acc_q.tm &&
							(req_q.timestamp_ms - acc_q.tm) < {32'd0, tmo_q}) begin
							rsp_q.throttled    <= 1'b1;
							rsp_q.remaining_ms <= tmo_q -
								32'(req_q.timestamp_ms - acc_q.tm);
						end else if (req_q.timestamp_ms <= acc_q.tm) begin
							rsp_q.throttled    <= 1'b1;
							rsp_q.remaining_ms <= tmo_q;
							rsp_q.last_time    <= req_q.timestamp_ms;
							wtm_q              <= req_q.timestamp_ms;
						end
					end
				end
				OP_FAIL: begin
					rsp_q.failure_count <= (acc_q.count == '1) ? acc_q.count
						: acc_q.count + 32'd1;
					wcnt_q              <= (acc_q.count == '1) ? acc_q.count
						: acc_q.count + 32'd1;
					rsp_q.last_time     <= req_q.timestamp_ms;
					wtm_q               <= req_q.timestamp_ms;
				end
				OP_CLEAR: begin
					rsp_q.failure_count <= '0;
					rsp_q.last_time     <= '0;
					wcnt_q              <= '0;
					wtm_q               <= '0;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	`UFTT_ASSERT_IMP(a_fill_max, clk, arst_n, 1'b1, fill_q <= CW'(ENTRIES))
	`UFTT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !req.ready)
	`UFTT_ASSERT_NXT(a_done_valid, clk, arst_n,
		state_q == ST_ROT && cnt_q == CW'(1), rsp.valid)
endmodule

/* rtl/uftt_cell.sv */
// one table slot of the ring: holds a record, compares it against the key when cmp is set
// depends on uftt_pkg
module uftt_cell import uftt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        shift,
	input  rec_t        rec_in,
	output rec_t        rec_out,
	input  logic [63:0] key,
	input  logic        cmp,
	input  scan_t       scan_in,
	output scan_t       scan_out
);
	logic        valid_q;
	logic [63:0] id_q;
	logic [31:0] count_q;
	logic [63:0] tm_q;

	// record storage, rotates one slot per shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q    <= rec_in.id;
			count_q <= rec_in.count;
			tm_q    <= rec_in.tm;
		end
	end

	assign rec_out = {valid_q, id_q, count_q, tm_q};

	// compare the head record against the key, track the oldest
	always_comb begin
		scan_out = scan_in;
		if (cmp && valid_q && !scan_in.hit) begin
			if (id_q == key) begin
				scan_out.hit   = 1'b1;
				scan_out.count = count_q;
				scan_out.tm    = tm_q;
			end else if (!scan_in.old_any || tm_q <= scan_in.old_tm) begin
				scan_out.old_any = 1'b1;
				scan_out.old_tm  = tm_q;
			end
		end
	end
endmodule
